// ===== rtl/core/cllp_pkg.sv =====
// Package: command codes and result type for the linked list pool.
`default_nettype none
package cllp_pkg;
  localparam logic [3:0] CMD_CREATE  = 4'd0;
  localparam logic [3:0] CMD_COUNT   = 4'd1;
  localparam logic [3:0] CMD_FIRST   = 4'd2;
  localparam logic [3:0] CMD_LAST    = 4'd3;
  localparam logic [3:0] CMD_NEXT    = 4'd4;
  localparam logic [3:0] CMD_PREV    = 4'd5;
  localparam logic [3:0] CMD_CURR    = 4'd6;
  localparam logic [3:0] CMD_INS_AFT = 4'd7;
  localparam logic [3:0] CMD_INS_BEF = 4'd8;
  localparam logic [3:0] CMD_APPEND  = 4'd9;
  localparam logic [3:0] CMD_PREPEND = 4'd10;
  localparam logic [3:0] CMD_REMOVE  = 4'd11;
  localparam logic [3:0] CMD_TRIM    = 4'd12;
  localparam logic [3:0] CMD_CONCAT  = 4'd13;
  localparam logic [3:0] CMD_FREE    = 4'd14;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  list_sel;
    logic [3:0]  second_list;
    logic [63:0] payload;
  } cmd_t;

  typedef struct packed {
    logic        status;
    logic [63:0] item_out;
    logic [3:0]  new_list;
    logic [8:0]  count;
  } rsp_t;
endpackage
`default_nettype wire

// ===== rtl/core/cllp_if.sv =====
// Interfaces: command and response channels with valid/ready.
`default_nettype none
interface cllp_cmd_if import cllp_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cllp_rsp_if import cllp_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cursor_linked_list_pool.sv =====
// Top level: linked list pool with cursors, node state in synchronous memories.
//
//  channel | dir | payload                               | handshake
//  cmd     | in  | kind, list_sel, second_list, payload  | valid/ready
//  rsp     | out | status, item_out, new_list, count     | valid/ready
//
// Node memory reads are registered; a cursor step chains two reads and a
// middle insert chains two reads and a link fix-up. Free walks its list,
// reading one node at a time. After reset a clearing pass fills every entry
// of the free node stack; no command is taken then. The response sits in an
// output register; a new command is taken only once the previous response
// has been transferred.
`default_nettype none
module cursor_linked_list_pool import cllp_pkg::*; #(
  parameter int NUM_NODES = 256,
  parameter int NUM_LISTS = 16
) (
  input  wire logic   clk,
  input  wire logic   rst,
  cllp_cmd_if.sink    cmd,
  cllp_rsp_if.source  rsp
);
  localparam int NW = $clog2(NUM_NODES);
  localparam int AW = NW + 1;            // node index with null marker
  localparam int LW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int LTW = $clog2(NUM_LISTS + 1);
  localparam logic [AW-1:0] NIL = AW'(NUM_NODES);

  // node memories and free node stack
  logic [63:0]   pay_mem [NUM_NODES];
  logic [AW-1:0] nxt_mem [NUM_NODES];
  logic [AW-1:0] prv_mem [NUM_NODES];
  logic [NW-1:0] fns_mem [NUM_NODES];

  // per-list registers (16 by default)
  logic [AW-1:0] head [NUM_LISTS];
  logic [AW-1:0] tail [NUM_LISTS];
  logic [AW-1:0] cur  [NUM_LISTS];
  logic [AW-1:0] pos  [NUM_LISTS];
  logic [AW-1:0] size [NUM_LISTS];
  logic [LW-1:0] fls  [NUM_LISTS];
  logic [LTW-1:0] fl_top;
  logic [AW-1:0]  fn_top;

  localparam logic [4:0] S_INIT = 5'd0,  S_IDLE = 5'd1,  S_DISP = 5'd2,
                         S_RD   = 5'd3,  S_RDW  = 5'd4,  S_INS1 = 5'd5,
                         S_INS2 = 5'd6,  S_INS3 = 5'd7,  S_INS4 = 5'd8,
                         S_REM1 = 5'd9,  S_REM2 = 5'd10, S_REM3 = 5'd11,
                         S_TRM1 = 5'd12, S_TRM2 = 5'd13, S_FRE1 = 5'd14,
                         S_FRE2 = 5'd15, S_DONE = 5'd16, S_TAKE = 5'd17,
                         S_TAKW = 5'd18;
  logic [4:0] state;

  cmd_t          c;
  logic [LW-1:0] l, l2;
  logic [AW-1:0] cidx, nn, pp, nx, walk, cnt_w;
  logic [NW-1:0] init_cnt;
  logic [63:0]   rd_pay;
  logic [AW-1:0] rd_nxt, rd_prv;
  logic [NW-1:0] rd_fns;
  logic          rsp_valid;
  rsp_t          rsp_q;
  logic [1:0]    phase;

  // single port access controls
  logic [NW-1:0] ra;
  logic          ren;

  assign cmd.ready = (state == S_IDLE) && !rsp_valid;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_q;

  always_ff @(posedge clk) begin
    if (ren) begin
      rd_pay <= pay_mem[ra];
      rd_nxt <= nxt_mem[ra];
      rd_prv <= prv_mem[ra];
      rd_fns <= fns_mem[ra];
    end
  end

  function automatic logic [NW-1:0] ni(input logic [AW-1:0] v);
    return v[NW-1:0];
  endfunction

  always_comb begin
    ren = 1'b0;
    ra  = '0;
    unique case (state)
      S_RD:   begin ren = 1'b1; ra = ni(cidx); end
      S_TAKE: begin ren = 1'b1; ra = ni(fn_top); end
      S_REM1: begin ren = 1'b1; ra = ni(cidx); end
      S_TRM1: begin ren = 1'b1; ra = ni(tail[l]); end
      S_FRE1: begin ren = 1'b1; ra = ni(walk); end
      S_INS1: begin ren = 1'b1; ra = ni(cidx); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_cnt  <= '0;
      rsp_valid <= 1'b0;
      fl_top    <= '0;
      fn_top    <= '0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        head[i] <= NIL; tail[i] <= NIL; cur[i] <= NIL;
        pos[i] <= '0; size[i] <= '0; fls[i] <= LW'(i);
      end
    end else begin
      if (rsp_valid && rsp.ready) rsp_valid <= 1'b0;
      unique case (state)
        S_INIT: begin
          fns_mem[init_cnt] <= init_cnt;
          init_cnt <= init_cnt + 1'b1;
          if (init_cnt == NW'(NUM_NODES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd.valid && cmd.ready) begin
            c     <= cmd.data;
            l     <= cmd.data.list_sel[LW-1:0];
            l2    <= cmd.data.second_list[LW-1:0];
            rsp_q <= '{status: 1'b1, item_out: 64'd0, new_list: 4'd0, count: 9'd0};
            state <= S_DISP;
          end
        end
        S_DISP: begin
          state <= S_DONE;
          cidx  <= cur[l];
          if (c.kind == CMD_CREATE) begin
            if (fl_top < LTW'(NUM_LISTS)) begin
              rsp_q.new_list <= 4'(fls[fl_top[LW-1:0]]);
              rsp_q.status   <= 1'b0;
              head[fls[fl_top[LW-1:0]]] <= NIL; tail[fls[fl_top[LW-1:0]]] <= NIL;
              cur[fls[fl_top[LW-1:0]]]  <= NIL;
              pos[fls[fl_top[LW-1:0]]]  <= '0; size[fls[fl_top[LW-1:0]]] <= '0;
              fl_top <= fl_top + 1'b1;
            end
          end else if (32'(c.list_sel) < NUM_LISTS) begin
            priority case (c.kind)
              CMD_COUNT: begin
                rsp_q.count <= 9'(size[l]); rsp_q.status <= 1'b0;
              end
              CMD_FIRST, CMD_LAST: if (size[l] != '0) begin
                cidx <= (c.kind == CMD_FIRST) ? head[l] : tail[l];
                cur[l] <= (c.kind == CMD_FIRST) ? head[l] : tail[l];
                pos[l] <= (c.kind == CMD_FIRST) ? AW'(1) : size[l];
                state <= S_RD;
              end
              CMD_NEXT: if (size[l] != '0) begin
                if (cur[l] == NIL) begin
                  if (pos[l] == '0) begin
                    cidx <= head[l]; cur[l] <= head[l]; pos[l] <= AW'(1);
                    phase <= 2'd3; state <= S_RD;
                  end
                end else begin
                  pos[l] <= pos[l] + 1'b1; phase <= 2'd0; state <= S_RD;
                end
              end
              CMD_PREV: if (size[l] != '0) begin
                if (cur[l] == NIL) begin
                  if (pos[l] != '0) begin
                    cidx <= tail[l]; cur[l] <= tail[l]; pos[l] <= size[l];
                    phase <= 2'd3; state <= S_RD;
                  end
                end else begin
                  if (pos[l] != '0) pos[l] <= pos[l] - 1'b1;
                  phase <= 2'd1; state <= S_RD;
                end
              end
              CMD_CURR: if (cur[l] != NIL) state <= S_RD;
              CMD_INS_AFT, CMD_INS_BEF, CMD_APPEND, CMD_PREPEND:
                if (fn_top < AW'(NUM_NODES)) state <= S_TAKE;
              CMD_REMOVE: if (cur[l] != NIL) state <= S_REM1;
              CMD_TRIM: if (size[l] != '0) state <= S_TRM1;
              CMD_CONCAT: if (32'(c.second_list) < NUM_LISTS && l2 != l) begin
                if (size[l2] != '0) begin
                  if (size[l] == '0) head[l] <= head[l2];
                  else begin
                    nxt_mem[ni(tail[l])] <= head[l2];
                    prv_mem[ni(head[l2])] <= tail[l];
                  end
                  size[l] <= size[l] + size[l2];
                  tail[l] <= tail[l2];
                  if (cur[l] == NIL && pos[l] != '0) pos[l] <= size[l] + size[l2] + 1'b1;
                end
                head[l2] <= NIL; tail[l2] <= NIL; cur[l2] <= NIL;
                pos[l2] <= '0; size[l2] <= '0;
                if (fl_top != '0) begin
                  fl_top <= fl_top - 1'b1;
                  fls[fl_top[LW-1:0] - 1'b1] <= l2;
                end
                rsp_q.status <= 1'b0;
              end
              CMD_FREE: begin
                walk <= head[l]; cnt_w <= '0; state <= S_FRE1;
              end
              default: ;
            endcase
          end
        end
        // cursor moves: read node at cidx, optionally step by its link
        S_RD: state <= S_RDW;
        S_RDW: begin
          if ((c.kind == CMD_NEXT || c.kind == CMD_PREV) && cidx == cur[l] &&
              phase != 2'd3) begin
            cidx  <= phase[0] ? rd_prv : rd_nxt;
            cur[l] <= phase[0] ? rd_prv : rd_nxt;
            phase <= 2'd3;
            state <= ((phase[0] ? rd_prv : rd_nxt) == NIL) ? S_DONE : S_RD;
          end else begin
            rsp_q.item_out <= rd_pay; rsp_q.status <= 1'b0; state <= S_DONE;
          end
        end
        // insert: pop a free node, then link it
        S_TAKE: state <= S_TAKW;
        S_TAKW: begin
          nn <= {1'b0, rd_fns};
          fn_top <= fn_top + 1'b1;
          pay_mem[rd_fns] <= c.payload;
          if (!(c.kind == CMD_APPEND || c.kind == CMD_PREPEND || pos[l] == '0 ||
                pos[l] > size[l] || cur[l] == NIL)) state <= S_INS1;
          else begin
            state <= S_INS3;
            // The new node's own links are set here so that S_INS3 only
            // touches the neighbour.
            if (c.kind == CMD_APPEND || (c.kind != CMD_PREPEND && pos[l] != '0)) begin
              nxt_mem[rd_fns] <= NIL; prv_mem[rd_fns] <= tail[l];
            end else begin
              prv_mem[rd_fns] <= NIL; nxt_mem[rd_fns] <= head[l];
            end
          end
        end
        S_INS1: state <= S_INS2;  // read cursor node links
        S_INS2: begin
          if (c.kind == CMD_INS_AFT) begin
            prv_mem[ni(nn)] <= cidx; nxt_mem[ni(nn)] <= rd_nxt; nx <= rd_nxt;
            if (cidx == tail[l]) tail[l] <= nn;
            pos[l] <= pos[l] + 1'b1;
          end else begin
            nxt_mem[ni(nn)] <= cidx; prv_mem[ni(nn)] <= rd_prv; nx <= rd_prv;
            if (cidx == head[l]) head[l] <= nn;
          end
          state <= S_INS4;
        end
        S_INS4: begin
          if (c.kind == CMD_INS_AFT) begin
            nxt_mem[ni(cidx)] <= nn;
            if (nx != NIL) prv_mem[ni(nx)] <= nn;
          end else begin
            prv_mem[ni(cidx)] <= nn;
            if (nx != NIL) nxt_mem[ni(nx)] <= nn;
          end
          cur[l] <= nn; size[l] <= size[l] + 1'b1; rsp_q.status <= 1'b0;
          state <= S_DONE;
        end
        S_INS3: begin
          if (c.kind == CMD_APPEND || (c.kind != CMD_PREPEND && pos[l] != '0)) begin
            if (tail[l] == NIL) head[l] <= nn; else nxt_mem[ni(tail[l])] <= nn;
            tail[l] <= nn; pos[l] <= size[l] + 1'b1;
          end else begin
            if (head[l] == NIL) tail[l] <= nn; else prv_mem[ni(head[l])] <= nn;
            head[l] <= nn; pos[l] <= AW'(1);
          end
          cur[l] <= nn; size[l] <= size[l] + 1'b1; rsp_q.status <= 1'b0;
          state <= S_DONE;
        end
        // remove at cursor
        S_REM1: state <= S_REM2;
        S_REM2: begin
          pp <= rd_prv; nx <= rd_nxt;
          if (rd_prv != NIL) nxt_mem[ni(rd_prv)] <= rd_nxt;
          rsp_q.item_out <= rd_pay;
          state <= S_REM3;
        end
        S_REM3: begin
          if (nx != NIL) begin
            cur[l] <= nx; prv_mem[ni(nx)] <= pp;
            if (cidx == head[l]) head[l] <= nx;
          end
          if (cidx == tail[l]) begin
            if (size[l] <= AW'(1)) begin
              pos[l] <= '0; head[l] <= NIL; tail[l] <= NIL;
            end else begin
              tail[l] <= pp; pos[l] <= size[l];
            end
            cur[l] <= NIL;
          end
          if (fn_top != '0) begin
            fn_top <= fn_top - 1'b1; fns_mem[ni(fn_top - 1'b1)] <= ni(cidx);
          end
          if (size[l] != '0) size[l] <= size[l] - 1'b1;
          rsp_q.status <= 1'b0; state <= S_DONE;
        end
        // trim the tail
        S_TRM1: state <= S_TRM2;
        S_TRM2: begin
          if (size[l] == AW'(1)) begin
            head[l] <= NIL; tail[l] <= NIL; cur[l] <= NIL;
          end else begin
            if (rd_prv != NIL) nxt_mem[ni(rd_prv)] <= NIL;
            tail[l] <= rd_prv; cur[l] <= rd_prv;
          end
          if (fn_top != '0) begin
            fn_top <= fn_top - 1'b1; fns_mem[ni(fn_top - 1'b1)] <= ni(tail[l]);
          end
          size[l] <= size[l] - 1'b1; pos[l] <= size[l] - 1'b1;
          rsp_q.item_out <= rd_pay; rsp_q.status <= 1'b0; state <= S_DONE;
        end
        // free: walk the list returning each node to the pool
        S_FRE1: begin
          if (cnt_w < size[l] && walk != NIL) state <= S_FRE2;
          else begin
            head[l] <= NIL; tail[l] <= NIL; cur[l] <= NIL;
            pos[l] <= '0; size[l] <= '0;
            if (fl_top != '0) begin
              fl_top <= fl_top - 1'b1; fls[fl_top[LW-1:0] - 1'b1] <= l;
            end
            rsp_q.status <= 1'b0; state <= S_DONE;
          end
        end
        S_FRE2: begin
          if (fn_top != '0) begin
            fn_top <= fn_top - 1'b1; fns_mem[ni(fn_top - 1'b1)] <= ni(walk);
          end
          walk <= rd_nxt; cnt_w <= cnt_w + 1'b1; state <= S_FRE1;
        end
        S_DONE: begin
          rsp_valid <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> !rsp_valid)
    else $error("response raised in cycle after a command transfer");
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    fn_top <= AW'(NUM_NODES))
    else $error("free node stack top beyond pool");
  a_list_bound: assert property (@(posedge clk) disable iff (rst)
    fl_top <= LTW'(NUM_LISTS))
    else $error("free list stack top beyond list count");
`endif
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for the cursor linked list pool: command stimulus, response prediction and checking.
`default_nettype none
module tb_top;
  import cllp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = 256;
  localparam int LISTS = 16;
  localparam logic [8:0] NIL = 9'd256;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam logic [3:0] CMD_UNUSED = 4'd15;

  logic clk;
  logic rst;

  cllp_cmd_if cmd_ch ();
  cllp_rsp_if rsp_ch ();

  cursor_linked_list_pool #(.NUM_NODES(NODES), .NUM_LISTS(LISTS)) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch.sink),
    .rsp(rsp_ch.source)
  );

  // Shadow copy of the pool.
  logic [63:0] pool_pay [NODES];
  logic [8:0]  pool_next [NODES];
  logic [8:0]  pool_prev [NODES];
  logic [7:0]  free_nodes [NODES];
  int          free_node_sp;
  logic [3:0]  free_lists [LISTS];
  int          free_list_sp;
  logic [8:0]  head [LISTS];
  logic [8:0]  tail [LISTS];
  logic [8:0]  cursor [LISTS];
  int          cpos [LISTS];
  int          csize [LISTS];
  bit          in_use [LISTS];

  rsp_t expected_rsp [$];
  int   n_sent, n_checked, n_errors, n_full_inserts, n_refused_creates;
  bit   quiet;
  int   cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("** cursor_linked_list_pool: FAILED **");
      $finish;
    end
  end

  function automatic void clear_list(logic [3:0] l);
    head[l] = NIL;
    tail[l] = NIL;
    cursor[l] = NIL;
    cpos[l] = 0;
    csize[l] = 0;
  endfunction

  function automatic logic [8:0] take_node(logic [63:0] pay);
    logic [8:0] n;
    if (free_node_sp >= NODES) return NIL;
    n = {1'b0, free_nodes[free_node_sp]};
    free_node_sp++;
    pool_pay[n] = pay;
    return n;
  endfunction

  function automatic void give_node(logic [8:0] n);
    if (n >= NIL || free_node_sp == 0) return;
    free_node_sp--;
    free_nodes[free_node_sp] = n[7:0];
  endfunction

  function automatic void give_list(logic [3:0] l);
    clear_list(l);
    in_use[l] = 1'b0;
    if (free_list_sp == 0) return;
    free_list_sp--;
    free_lists[free_list_sp] = l;
  endfunction

  function automatic void set_next(logic [8:0] n, logic [8:0] v);
    if (n < NIL) pool_next[n] = v;
  endfunction

  function automatic void set_prev(logic [8:0] n, logic [8:0] v);
    if (n < NIL) pool_prev[n] = v;
  endfunction

  function automatic void link_front(logic [3:0] l, logic [8:0] n);
    set_prev(n, NIL);
    set_next(n, head[l]);
    if (head[l] == NIL) tail[l] = n;
    else set_prev(head[l], n);
    head[l] = n;
    cpos[l] = 1;
  endfunction

  function automatic void link_back(logic [3:0] l, logic [8:0] n);
    set_next(n, NIL);
    set_prev(n, tail[l]);
    if (tail[l] == NIL) head[l] = n;
    else set_next(tail[l], n);
    tail[l] = n;
    cpos[l] = csize[l] + 1;
  endfunction

  // Applies one command to the shadow pool and returns the response it must give.
  function automatic rsp_t pool_apply(cmd_t c);
    rsp_t r;
    logic [3:0] l, l2;
    logic [8:0] cur, n, p, nx;
    bit hit;
    int i;
    r = '0;
    r.status = 1'b1;
    hit = 1'b0;
    l = c.list_sel;
    l2 = c.second_list;
    if (c.kind == CMD_CREATE) begin
      if (free_list_sp < LISTS) begin
        r.new_list = free_lists[free_list_sp];
        free_list_sp++;
        clear_list(r.new_list);
        in_use[r.new_list] = 1'b1;
        r.status = 1'b0;
      end
    end else begin
      cur = cursor[l];
      case (c.kind)
        CMD_COUNT: begin
          r.count = 9'(csize[l]);
          r.status = 1'b0;
        end
        CMD_FIRST, CMD_LAST: begin
          if (csize[l] != 0) begin
            cursor[l] = (c.kind == CMD_FIRST) ? head[l] : tail[l];
            cpos[l] = (c.kind == CMD_FIRST) ? 1 : csize[l];
            hit = 1'b1;
          end
        end
        CMD_NEXT: begin
          if (csize[l] != 0) begin
            if (cur == NIL) begin
              if (cpos[l] == 0) begin
                cursor[l] = head[l];
                cpos[l] = 1;
                hit = 1'b1;
              end
            end else begin
              cursor[l] = pool_next[cur];
              cpos[l]++;
              hit = cursor[l] != NIL;
            end
          end
        end
        CMD_PREV: begin
          if (csize[l] != 0) begin
            if (cur == NIL) begin
              if (cpos[l] != 0) begin
                cursor[l] = tail[l];
                cpos[l] = csize[l];
                hit = 1'b1;
              end
            end else begin
              cursor[l] = pool_prev[cur];
              if (cpos[l] != 0) cpos[l]--;
              hit = cursor[l] != NIL;
            end
          end
        end
        CMD_CURR: hit = cur != NIL;
        CMD_INS_AFT, CMD_INS_BEF, CMD_APPEND, CMD_PREPEND: begin
          n = take_node(c.payload);
          if (n != NIL) begin
            if (c.kind == CMD_APPEND) begin
              link_back(l, n);
            end else if (c.kind == CMD_PREPEND || cpos[l] == 0) begin
              link_front(l, n);
            end else if (cpos[l] > csize[l] || cur == NIL) begin
              link_back(l, n);
            end else if (c.kind == CMD_INS_AFT) begin
              nx = pool_next[cur];
              set_prev(n, cur);
              set_next(n, nx);
              if (nx != NIL) set_prev(nx, n);
              if (cur == tail[l]) tail[l] = n;
              set_next(cur, n);
              cpos[l]++;
            end else begin
              p = pool_prev[cur];
              set_next(n, cur);
              set_prev(n, p);
              if (p != NIL) set_next(p, n);
              if (cur == head[l]) head[l] = n;
              set_prev(cur, n);
            end
            cursor[l] = n;
            csize[l]++;
            r.status = 1'b0;
          end
        end
        CMD_REMOVE: begin
          if (cur != NIL) begin
            p = pool_prev[cur];
            nx = pool_next[cur];
            if (p != NIL) set_next(p, nx);
            if (nx != NIL) begin
              cursor[l] = nx;
              set_prev(nx, p);
              if (cur == head[l]) head[l] = nx;
            end
            if (cur == tail[l]) begin
              if (csize[l] <= 1) begin
                cpos[l] = 0;
                head[l] = NIL;
                tail[l] = NIL;
              end else begin
                tail[l] = p;
                cpos[l] = csize[l];
              end
              cursor[l] = NIL;
            end
            r.item_out = pool_pay[cur];
            give_node(cur);
            if (csize[l] != 0) csize[l]--;
            r.status = 1'b0;
          end
        end
        CMD_TRIM: begin
          if (csize[l] != 0) begin
            n = tail[l];
            if (csize[l] == 1) begin
              head[l] = NIL;
              tail[l] = NIL;
              cursor[l] = NIL;
            end else begin
              p = pool_prev[n];
              set_next(p, NIL);
              tail[l] = p;
              cursor[l] = p;
            end
            r.item_out = pool_pay[n];
            give_node(n);
            csize[l]--;
            cpos[l] = csize[l];
            r.status = 1'b0;
          end
        end
        CMD_CONCAT: begin
          if (l2 != l) begin
            if (csize[l2] != 0) begin
              if (csize[l] == 0) begin
                head[l] = head[l2];
              end else begin
                set_next(tail[l], head[l2]);
                set_prev(head[l2], tail[l]);
              end
              csize[l] += csize[l2];
              tail[l] = tail[l2];
              if (cur == NIL && cpos[l] != 0) cpos[l] = csize[l] + 1;
            end
            give_list(l2);
            r.status = 1'b0;
          end
        end
        CMD_FREE: begin
          n = head[l];
          for (i = 0; i < csize[l] && n != NIL; i++) begin
            nx = pool_next[n];
            give_node(n);
            n = nx;
          end
          give_list(l);
          r.status = 1'b0;
        end
        default: ;
      endcase
      if (hit) begin
        r.status = 1'b0;
        r.item_out = pool_pay[cursor[l]];
      end
    end
    return r;
  endfunction

  task automatic send_cmd(input logic [3:0] k, input logic [3:0] l, input logic [3:0] l2,
                          input logic [63:0] pay);
    cmd_t c;
    rsp_t r;
    c.kind = k;
    c.list_sel = l;
    c.second_list = l2;
    c.payload = pay;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data <= c;
    do @(posedge clk); while (!cmd_ch.ready);
    r = pool_apply(c);
    if (r.status && (k == CMD_APPEND || k == CMD_PREPEND || k == CMD_INS_AFT
        || k == CMD_INS_BEF)) n_full_inserts++;
    if (r.status && k == CMD_CREATE) n_refused_creates++;
    expected_rsp.push_back(r);
    n_sent++;
  endtask

  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_pay();
    return {$urandom, $urandom};
  endfunction

  // Returns a random list that is in use, or -1 if none is.
  function automatic int pick_list();
    int idx [$];
    for (int i = 0; i < LISTS; i++) if (in_use[i]) idx.push_back(i);
    if (idx.size() == 0) return -1;
    return idx[$urandom_range(0, idx.size() - 1)];
  endfunction

  task automatic free_all();
    for (int i = 0; i < LISTS; i++)
      if (in_use[i]) send_cmd(CMD_FREE, i[3:0], 4'hf, 64'd0);
  endtask

  task automatic test_directed();
    logic [3:0] a, b;
    send_cmd(CMD_CREATE, 4'd0, 4'd0, 64'd0);
    a = 4'd0;
    send_cmd(CMD_COUNT, a, 4'd0, 64'd0);
    send_cmd(CMD_FIRST, a, 4'd0, 64'd0);
    send_cmd(CMD_NEXT, a, 4'd0, 64'd0);
    send_cmd(CMD_PREV, a, 4'd0, 64'd0);
    send_cmd(CMD_CURR, a, 4'd0, 64'd0);
    // Inserts on an empty list and before the start prepend.
    send_cmd(CMD_INS_AFT, a, 4'd0, 64'hffff_ffff_ffff_ffff);
    send_cmd(CMD_APPEND, a, 4'd0, 64'd0);
    send_cmd(CMD_PREPEND, a, 4'd0, 64'h5555_aaaa_5555_aaaa);
    send_cmd(CMD_INS_BEF, a, 4'd0, 64'haaaa_5555_aaaa_5555);
    send_cmd(CMD_LAST, a, 4'd0, 64'd0);
    send_cmd(CMD_NEXT, a, 4'd0, 64'd0);
    send_cmd(CMD_INS_BEF, a, 4'd0, 64'h1);
    send_cmd(CMD_REMOVE, a, 4'd0, 64'd0);
    send_cmd(CMD_CREATE, 4'd0, 4'd0, 64'd0);
    b = 4'd1;
    send_cmd(CMD_APPEND, b, 4'd0, 64'h8000_0000_0000_0000);
    send_cmd(CMD_REMOVE, b, 4'd0, 64'd0);
    send_cmd(CMD_APPEND, b, 4'd0, 64'h7);
    send_cmd(CMD_CONCAT, a, a, 64'd0);
    send_cmd(CMD_NEXT, a, 4'd0, 64'd0);
    send_cmd(CMD_CONCAT, a, b, 64'd0);
    send_cmd(CMD_TRIM, a, 4'd0, 64'd0);
    send_cmd(CMD_UNUSED, a, 4'd0, 64'd0);
    send_cmd(CMD_FREE, a, 4'd0, 64'd0);
    // The free stack is full now, so a further release pushes nothing.
    send_cmd(CMD_FREE, a, 4'd0, 64'd0);
  endtask

  task automatic test_list_limit();
    for (int i = 0; i <= LISTS; i++)
      send_cmd(CMD_CREATE, 4'($urandom), 4'($urandom), rand_pay());
    free_all();
  endtask

  task automatic test_pool_limit();
    logic [3:0] a;
    send_cmd(CMD_CREATE, 4'd0, 4'd0, 64'd0);
    a = 4'(pick_list());
    while (free_node_sp < NODES)
      send_cmd($urandom_range(0, 1) ? CMD_APPEND : CMD_PREPEND, a, 4'($urandom), rand_pay());
    send_cmd(CMD_INS_AFT, a, 4'd0, rand_pay());
    send_cmd(CMD_INS_BEF, a, 4'd0, rand_pay());
    send_cmd(CMD_APPEND, a, 4'd0, rand_pay());
    send_cmd(CMD_PREPEND, a, 4'd0, rand_pay());
    send_cmd(CMD_COUNT, a, 4'd0, 64'd0);
    send_cmd(CMD_FREE, a, 4'd0, 64'd0);
  endtask

  task automatic random_cmd(int grow_pct);
    int l, l2, r;
    logic [3:0] k;
    l = pick_list();
    if (l < 0 || $urandom_range(0, 99) < 3) begin
      send_cmd(CMD_CREATE, 4'($urandom), 4'($urandom), rand_pay());
      return;
    end
    r = $urandom_range(0, 99);
    if (r < grow_pct) begin
      k = CMD_INS_AFT + 4'($urandom_range(0, 3));
    end else begin
      r = $urandom_range(0, 99);
      if (r < 8) k = CMD_COUNT;
      else if (r < 50) k = CMD_FIRST + 4'($urandom_range(0, 4));
      else if (r < 75) k = CMD_REMOVE;
      else if (r < 88) k = CMD_TRIM;
      else if (r < 95) k = CMD_CONCAT;
      else if (r < 98) k = CMD_FREE;
      else k = CMD_UNUSED;
    end
    l2 = $urandom_range(0, 15);
    if (k == CMD_CONCAT) begin
      l2 = pick_list();
      if ($urandom_range(0, 4) == 0) l2 = l;
    end
    send_cmd(k, l[3:0], l2[3:0], rand_pay());
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) quiet = 1'b1;
      for (int i = 0; i < 240; i++) random_cmd((ph % 2 == 0) ? 65 : 30);
      if (ph == 3) begin
        wait_drained();
        repeat (20) @(posedge clk);
      end
    end
  endtask

  always @(posedge clk) begin : rsp_side
    int hold;
    rsp_t exp_r;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      n_checked++;
      if (expected_rsp.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("Unexpected response %p", rsp_ch.data);
      end else begin
        exp_r = expected_rsp.pop_front();
        if (rsp_ch.data.status !== exp_r.status || rsp_ch.data.item_out !== exp_r.item_out
            || rsp_ch.data.new_list !== exp_r.new_list || rsp_ch.data.count !== exp_r.count)
        begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("Mismatch on response %0d: expected st=%0b item=%h new=%0d cnt=%0d",
                     n_checked, exp_r.status, exp_r.item_out, exp_r.new_list, exp_r.count);
            $display("  got st=%0b item=%h new=%0d cnt=%0d",
                     rsp_ch.data.status, rsp_ch.data.item_out, rsp_ch.data.new_list,
                     rsp_ch.data.count);
          end
        end
      end
    end
    if (quiet) begin
      rsp_ch.ready <= 1'b1;
    end else if (hold > 0) begin
      hold--;
    end else if ($urandom_range(0, 5) == 0) begin
      rsp_ch.ready <= 1'b0;
      hold = $urandom_range(0, 12);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  initial begin
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    rsp_ch.ready = 1'b0;
    quiet = 1'b0;
    cycles = 0;
    free_node_sp = 0;
    free_list_sp = 0;
    for (int i = 0; i < NODES; i++) free_nodes[i] = 8'(i);
    for (int i = 0; i < LISTS; i++) begin
      free_lists[i] = 4'(i);
      in_use[i] = 1'b0;
      clear_list(4'(i));
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_list_limit();
    test_pool_limit();
    test_random();
    wait_drained();
    repeat (50) @(posedge clk);
    $display("Covered %0d commands, %0d responses checked, %0d inserts into a full pool",
             n_sent, n_checked, n_full_inserts);
    $display("and %0d creates refused for want of a free list.", n_refused_creates);
    if (n_errors == 0 && expected_rsp.size() == 0) begin
      $display("** cursor_linked_list_pool: PASSED **");
    end else begin
      $display("%0d mismatches, %0d responses outstanding", n_errors, expected_rsp.size());
      $display("** cursor_linked_list_pool: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire
